// ===== design/avz_pkg.sv =====
package avz_pkg;

  // Default number of fraction bits of the matrix entries
  localparam int OutFracBits = 30;

  // Width of one input component and of one matrix entry
  localparam int VecW = 32;
  localparam int RotW = 32;

  // Width of a sum of squares (three 63-bit squares)
  localparam int SqSumW = 64;

  // Ratio lanes carried through the cell chain
  localparam int NumLanes = 6;
  localparam int LaneUR = 0;  // |u|/r
  localparam int LaneVR = 1;  // |v|/r
  localparam int LaneUB = 2;  // |u|/R
  localparam int LaneVB = 3;  // |v|/R
  localparam int LaneWB = 4;  // |w|/R
  localparam int LaneRB = 5;  // r/R

  // Control that travels alongside one item
  typedef struct packed {
    logic valid;
    logic degen;
    logic neg_u;
    logic neg_v;
    logic neg_w;
  } meta_t;

endpackage

// ===== design/avz_front.sv =====
module avz_front #(
  parameter int F  = avz_pkg::OutFracBits,
  parameter int EW = 2 * F + 68
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   take,
  input  logic signed [avz_pkg::VecW-1:0]        vec_x,
  input  logic signed [avz_pkg::VecW-1:0]        vec_y,
  input  logic signed [avz_pkg::VecW-1:0]        vec_z,
  output avz_pkg::meta_t                         meta_out,
  output logic [avz_pkg::NumLanes-1:0][EW-1:0]   e_out,
  output logic [avz_pkg::NumLanes-1:0][EW-1:0]   p_out,
  output logic [avz_pkg::NumLanes-1:0][avz_pkg::SqSumW-1:0] den_out,
  output logic [avz_pkg::NumLanes-1:0][F:0]      q_out
);

  localparam int VW = avz_pkg::VecW;
  localparam int SW = avz_pkg::SqSumW;

  avz_pkg::meta_t meta1, meta2;
  logic [VW-1:0]   au, av, aw;
  logic [SW-1:0]   su2, sv2, sw2;
  logic [SW-1:0]   r2, big2;

  // Stage 1: take magnitudes and signs
  always_ff @(posedge clk) begin
    if (rst) begin
      meta1.valid <= 1'b0;
    end else begin
      meta1.valid <= take;
    end
    meta1.degen <= 1'b0;
    meta1.neg_u <= vec_x[VW-1];
    meta1.neg_v <= vec_y[VW-1];
    meta1.neg_w <= vec_z[VW-1];
    au <= vec_x[VW-1] ? (~vec_x + 1'b1) : vec_x;
    av <= vec_y[VW-1] ? (~vec_y + 1'b1) : vec_y;
    aw <= vec_z[VW-1] ? (~vec_z + 1'b1) : vec_z;
  end

  // Stage 2: square each magnitude
  always_ff @(posedge clk) begin
    if (rst) begin
      meta2.valid <= 1'b0;
    end else begin
      meta2.valid <= meta1.valid;
    end
    meta2.degen <= meta1.degen;
    meta2.neg_u <= meta1.neg_u;
    meta2.neg_v <= meta1.neg_v;
    meta2.neg_w <= meta1.neg_w;
    su2 <= SW'(au) * SW'(au);
    sv2 <= SW'(av) * SW'(av);
    sw2 <= SW'(aw) * SW'(aw);
  end

  assign r2   = su2 + sv2;
  assign big2 = r2 + sw2;

  // Stage 3: form sums and load the lanes of the first cell
  always_ff @(posedge clk) begin
    if (rst) begin
      meta_out.valid <= 1'b0;
    end else begin
      meta_out.valid <= meta2.valid;
    end
    meta_out.degen <= (r2 == '0);
    meta_out.neg_u <= meta2.neg_u;
    meta_out.neg_v <= meta2.neg_v;
    meta_out.neg_w <= meta2.neg_w;
    e_out[avz_pkg::LaneUR] <= EW'(su2) << (2 * F);
    e_out[avz_pkg::LaneVR] <= EW'(sv2) << (2 * F);
    e_out[avz_pkg::LaneUB] <= EW'(su2) << (2 * F);
    e_out[avz_pkg::LaneVB] <= EW'(sv2) << (2 * F);
    e_out[avz_pkg::LaneWB] <= EW'(sw2) << (2 * F);
    e_out[avz_pkg::LaneRB] <= EW'(r2) << (2 * F);
    den_out[avz_pkg::LaneUR] <= r2;
    den_out[avz_pkg::LaneVR] <= r2;
    den_out[avz_pkg::LaneUB] <= big2;
    den_out[avz_pkg::LaneVB] <= big2;
    den_out[avz_pkg::LaneWB] <= big2;
    den_out[avz_pkg::LaneRB] <= big2;
    p_out <= '0;
    q_out <= '0;
  end

endmodule

// ===== design/avz_cell.sv =====
module avz_cell #(
  parameter int F  = avz_pkg::OutFracBits,
  parameter int EW = 2 * F + 68,
  parameter int B  = 0
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  avz_pkg::meta_t                         meta_in,
  input  logic [avz_pkg::NumLanes-1:0][EW-1:0]   e_in,
  input  logic [avz_pkg::NumLanes-1:0][EW-1:0]   p_in,
  input  logic [avz_pkg::NumLanes-1:0][avz_pkg::SqSumW-1:0] den_in,
  input  logic [avz_pkg::NumLanes-1:0][F:0]      q_in,
  output avz_pkg::meta_t                         meta_out,
  output logic [avz_pkg::NumLanes-1:0][EW-1:0]   e_out,
  output logic [avz_pkg::NumLanes-1:0][EW-1:0]   p_out,
  output logic [avz_pkg::NumLanes-1:0][avz_pkg::SqSumW-1:0] den_out,
  output logic [avz_pkg::NumLanes-1:0][F:0]      q_out
);

  // One result bit of every ratio: with E = T - q^2*den and P = q*den,
  // setting bit B costs (P << (B+1)) + (den << 2B).
  for (genvar i = 0; i < avz_pkg::NumLanes; i++) begin : g_lane
    logic [EW-1:0] cost;
    logic          fits;

    assign cost = (p_in[i] << (B + 1)) + (EW'(den_in[i]) << (2 * B));
    assign fits = (e_in[i] >= cost);

    always_ff @(posedge clk) begin
      e_out[i]   <= fits ? (e_in[i] - cost) : e_in[i];
      p_out[i]   <= fits ? (p_in[i] + (EW'(den_in[i]) << B)) : p_in[i];
      q_out[i]   <= q_in[i] | ((F + 1)'(fits) << B);
      den_out[i] <= den_in[i];
    end
  end

  // Advance the item's control
  always_ff @(posedge clk) begin
    if (rst) begin
      meta_out.valid <= 1'b0;
    end else begin
      meta_out.valid <= meta_in.valid;
    end
    meta_out.degen <= meta_in.degen;
    meta_out.neg_u <= meta_in.neg_u;
    meta_out.neg_v <= meta_in.neg_v;
    meta_out.neg_w <= meta_in.neg_w;
  end

endmodule

// ===== design/avz_back.sv =====
module avz_back #(
  parameter int F = avz_pkg::OutFracBits
) (
  input  logic                                clk,
  input  logic                                rst,
  input  avz_pkg::meta_t                      meta_in,
  input  logic [avz_pkg::NumLanes-1:0][F:0]   q_in,
  output logic                                done,
  output logic signed [avz_pkg::RotW-1:0]     rot_00,
  output logic signed [avz_pkg::RotW-1:0]     rot_01,
  output logic signed [avz_pkg::RotW-1:0]     rot_02,
  output logic signed [avz_pkg::RotW-1:0]     rot_10,
  output logic signed [avz_pkg::RotW-1:0]     rot_11,
  output logic signed [avz_pkg::RotW-1:0]     rot_12,
  output logic signed [avz_pkg::RotW-1:0]     rot_20,
  output logic signed [avz_pkg::RotW-1:0]     rot_22,
  output logic                                degenerate
);

  localparam int RW = avz_pkg::RotW;
  localparam int PW = 2 * F + 2;

  avz_pkg::meta_t                    meta1;
  logic [avz_pkg::NumLanes-1:0][F:0] q1;
  logic [PW-1:0]                     prod_u, prod_v;

  function automatic logic [RW-1:0] signed_mag(input logic [F:0] mag, input logic neg);
    logic [RW-1:0] ext;
    ext = RW'(mag);
    return neg ? (~ext + 1'b1) : ext;
  endfunction

  // Stage 1: products for the two composite entries
  always_ff @(posedge clk) begin
    if (rst) begin
      meta1.valid <= 1'b0;
    end else begin
      meta1.valid <= meta_in.valid;
    end
    meta1.degen <= meta_in.degen;
    meta1.neg_u <= meta_in.neg_u;
    meta1.neg_v <= meta_in.neg_v;
    meta1.neg_w <= meta_in.neg_w;
    q1     <= q_in;
    prod_u <= PW'(q_in[avz_pkg::LaneUR]) * PW'(q_in[avz_pkg::LaneWB]);
    prod_v <= PW'(q_in[avz_pkg::LaneVR]) * PW'(q_in[avz_pkg::LaneWB]);
  end

  // Stage 2: apply signs, zero a degenerate item, and present the result
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= meta1.valid;
    end
    degenerate <= meta1.degen;
    if (meta1.degen) begin
      rot_00 <= '0;
      rot_01 <= '0;
      rot_02 <= '0;
      rot_10 <= '0;
      rot_11 <= '0;
      rot_12 <= '0;
      rot_20 <= '0;
      rot_22 <= '0;
    end else begin
      rot_00 <= signed_mag(prod_u[F +: F + 1], meta1.neg_u ^ meta1.neg_w);
      rot_01 <= signed_mag(q1[avz_pkg::LaneVR], !meta1.neg_v);
      rot_02 <= signed_mag(q1[avz_pkg::LaneUB], meta1.neg_u);
      rot_10 <= signed_mag(prod_v[F +: F + 1], meta1.neg_v ^ meta1.neg_w);
      rot_11 <= signed_mag(q1[avz_pkg::LaneUR], meta1.neg_u);
      rot_12 <= signed_mag(q1[avz_pkg::LaneVB], meta1.neg_v);
      rot_20 <= signed_mag(q1[avz_pkg::LaneRB], 1'b1);
      rot_22 <= signed_mag(q1[avz_pkg::LaneWB], meta1.neg_w);
    end
  end

endmodule

// ===== design/align_vector_to_z_rotation_core.sv =====
// Channel   Ports                               Transfer
// input     start, busy, vec_x/y/z              start high while busy low
// result    done, rot_*, degenerate             done high for one cycle
//
// One vector enters every cycle; busy stays low.
// The pipeline has three front stages, one cell per result bit of the six root
// ratios (OUT_FRAC_BITS + 1 cells), and two back stages.
// Reset clears only the valid bits along the chain.
// The receiver cannot stall; each result shows on done for exactly one cycle.
module align_vector_to_z_rotation_core #(
  parameter int OUT_FRAC_BITS = avz_pkg::OutFracBits
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [avz_pkg::VecW-1:0] vec_x,
  input  logic signed [avz_pkg::VecW-1:0] vec_y,
  input  logic signed [avz_pkg::VecW-1:0] vec_z,
  output logic                            done,
  output logic signed [avz_pkg::RotW-1:0] rot_00,
  output logic signed [avz_pkg::RotW-1:0] rot_01,
  output logic signed [avz_pkg::RotW-1:0] rot_02,
  output logic signed [avz_pkg::RotW-1:0] rot_10,
  output logic signed [avz_pkg::RotW-1:0] rot_11,
  output logic signed [avz_pkg::RotW-1:0] rot_12,
  output logic signed [avz_pkg::RotW-1:0] rot_20,
  output logic signed [avz_pkg::RotW-1:0] rot_22,
  output logic                            degenerate
);

  localparam int F  = OUT_FRAC_BITS;
  localparam int EW = 2 * F + 68;
  localparam int NL = avz_pkg::NumLanes;
  localparam int SW = avz_pkg::SqSumW;

  avz_pkg::meta_t             meta_s [F+2];
  logic [NL-1:0][EW-1:0]      e_s    [F+2];
  logic [NL-1:0][EW-1:0]      p_s    [F+2];
  logic [NL-1:0][SW-1:0]      den_s  [F+2];
  logic [NL-1:0][F:0]         q_s    [F+2];

  // Pipeline never holds off a new vector
  assign busy = 1'b0;

  avz_front #(.F(F), .EW(EW)) u_front (
    .clk      (clk),
    .rst      (rst),
    .take     (start & ~busy),
    .vec_x    (vec_x),
    .vec_y    (vec_y),
    .vec_z    (vec_z),
    .meta_out (meta_s[0]),
    .e_out    (e_s[0]),
    .p_out    (p_s[0]),
    .den_out  (den_s[0]),
    .q_out    (q_s[0])
  );

  // Chain of cells, most significant result bit first
  for (genvar k = 0; k <= F; k++) begin : g_cell
    avz_cell #(.F(F), .EW(EW), .B(F - k)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .meta_in  (meta_s[k]),
      .e_in     (e_s[k]),
      .p_in     (p_s[k]),
      .den_in   (den_s[k]),
      .q_in     (q_s[k]),
      .meta_out (meta_s[k+1]),
      .e_out    (e_s[k+1]),
      .p_out    (p_s[k+1]),
      .den_out  (den_s[k+1]),
      .q_out    (q_s[k+1])
    );
  end

  avz_back #(.F(F)) u_back (
    .clk        (clk),
    .rst        (rst),
    .meta_in    (meta_s[F+1]),
    .q_in       (q_s[F+1]),
    .done       (done),
    .rot_00     (rot_00),
    .rot_01     (rot_01),
    .rot_02     (rot_02),
    .rot_10     (rot_10),
    .rot_11     (rot_11),
    .rot_12     (rot_12),
    .rot_20     (rot_20),
    .rot_22     (rot_22),
    .degenerate (degenerate)
  );

endmodule

// ===== dv/align_vector_to_z_rotation_core_tb.sv =====
module align_vector_to_z_rotation_core_tb;

  localparam int FracBits = avz_pkg::OutFracBits;
  localparam int IdleLimit = 2000;
  localparam int DrainCycles = FracBits + 20;

  typedef struct packed {
    logic signed [avz_pkg::RotW-1:0] m00, m01, m02, m10, m11, m12, m20, m22;
    logic                            degen;
  } rot_set_t;

  // Keep the expected matrices in transfer order and compare each arrival
  class rotation_scoreboard;
    rot_set_t pending_q[$];
    int       errors;
    int       checked;
    int       degen_seen;

    // Return floor(2^F * sqrt(nsq/den)); den nonzero, nsq <= den
    function automatic logic [63:0] root_ratio(logic [63:0] nsq, logic [63:0] den);
      logic [63:0]  q;
      logic [63:0]  c;
      logic [127:0] lhs;
      logic [127:0] rhs;
      q = 0;
      rhs = {64'd0, nsq} << (2 * FracBits);
      for (int b = FracBits; b >= 0; b--) begin
        c = q | (64'd1 << b);
        lhs = {64'd0, c * c} * {64'd0, den};
        if (lhs <= rhs) q = c;
      end
      return q;
    endfunction

    function automatic logic [avz_pkg::RotW-1:0] signed_entry(logic [63:0] mag, logic neg);
      return neg ? avz_pkg::RotW'(-mag) : avz_pkg::RotW'(mag);
    endfunction

    // Work out the expected matrix for one accepted vector
    function void note_vector(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      rot_set_t    e;
      logic [63:0] au, av, aw, r2, b2;
      logic [63:0] ur, vr, ub, vb, wb, rb;
      au = x[31] ? 64'(-{32'd0, x} & 64'hFFFF_FFFF) : {32'd0, x};
      av = y[31] ? 64'(-{32'd0, y} & 64'hFFFF_FFFF) : {32'd0, y};
      aw = z[31] ? 64'(-{32'd0, z} & 64'hFFFF_FFFF) : {32'd0, z};
      r2 = au * au + av * av;
      e = '0;
      if (r2 == 0) begin
        e.degen = 1'b1;
      end else begin
        b2 = r2 + aw * aw;
        ur = root_ratio(au * au, r2);
        vr = root_ratio(av * av, r2);
        ub = root_ratio(au * au, b2);
        vb = root_ratio(av * av, b2);
        wb = root_ratio(aw * aw, b2);
        rb = root_ratio(r2, b2);
        e.m00 = signed_entry((ur * wb) >> FracBits, x[31] != z[31]);
        e.m01 = signed_entry(vr, !y[31]);
        e.m02 = signed_entry(ub, x[31]);
        e.m10 = signed_entry((vr * wb) >> FracBits, y[31] != z[31]);
        e.m11 = signed_entry(ur, x[31]);
        e.m12 = signed_entry(vb, y[31]);
        e.m20 = signed_entry(rb, 1'b1);
        e.m22 = signed_entry(wb, z[31]);
      end
      pending_q.push_back(e);
    endfunction

    function void cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %0d, got %0d", name, $signed(exp_v), $signed(act_v));
        errors++;
      end
    endfunction

    // Compare one result with the oldest expectation
    function void check_result(rot_set_t a);
      rot_set_t e;
      if (pending_q.size() == 0) begin
        $error("result arrived with no vector outstanding");
        errors++;
        return;
      end
      e = pending_q.pop_front();
      checked++;
      if (a.degen) degen_seen++;
      cmp("rot_00", e.m00, a.m00);
      cmp("rot_01", e.m01, a.m01);
      cmp("rot_02", e.m02, a.m02);
      cmp("rot_10", e.m10, a.m10);
      cmp("rot_11", e.m11, a.m11);
      cmp("rot_12", e.m12, a.m12);
      cmp("rot_20", e.m20, a.m20);
      cmp("rot_22", e.m22, a.m22);
      cmp("degenerate", 32'(e.degen), 32'(a.degen));
    endfunction
  endclass

  logic clk, rst, start, busy, done, degenerate;
  logic signed [avz_pkg::VecW-1:0] vec_x, vec_y, vec_z;
  logic signed [avz_pkg::RotW-1:0] rot_00, rot_01, rot_02, rot_10, rot_11, rot_12;
  logic signed [avz_pkg::RotW-1:0] rot_20, rot_22;

  rotation_scoreboard sb;
  int idle_pct;
  int quiet_cycles;

  align_vector_to_z_rotation_core dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Check every strobed result and watch for a stall
  always @(posedge clk) begin
    if (!rst) begin
      if (done)
        sb.check_result({rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_20, rot_22,
                         degenerate});
      if (done || (start && !busy)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IdleLimit) begin
        $display("watchdog: no transfer for %0d cycles", IdleLimit);
        $display("align_vector_to_z_rotation_core_tb: done, errors");
        $finish;
      end
    end
  end

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'(int'($urandom_range(0, 8)) - 4);
      3: return 32'(int'($urandom_range(0, 2 ** 20)) - 2 ** 19);
      4: return 32'd0;
      default: return $urandom;
    endcase
  endfunction

  // Offer one vector, idle at random first, hold until it transfers
  task automatic send_vector(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    vec_x <= x;
    vec_y <= y;
    vec_z <= z;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_vector(x, y, z);
  endtask

  initial begin
    logic [31:0] corners[6];
    sb = new();
    rst <= 1'b1;
    start <= 1'b0;
    vec_x <= '0;
    vec_y <= '0;
    vec_z <= '0;
    idle_pct = 0;
    quiet_cycles = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: degenerate vectors, axes, extremes
    send_vector(0, 0, 0);
    send_vector(0, 0, 32'h0001_0000);
    send_vector(0, 0, 32'h8000_0000);
    send_vector(32'h0001_0000, 0, 0);
    send_vector(0, 32'hFFFF_0000, 0);
    corners = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'h0001_0000};
    for (int i = 0; i < 6; i++)
      send_vector(corners[i], corners[(i + 1) % 6], corners[(i + 3) % 6]);
    send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vector(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_vector(32'h0003_0000, 32'h0004_0000, 32'hFFF4_0000);

    // Random in phases of idling
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 0) ? 0 : (ph == 1) ? 61 : (ph == 2) ? 0 : 26;
      for (int n = 0; n < 460; n++) send_vector(rand_comp(), rand_comp(), rand_comp());
    end
    start <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    $display("checked %0d matrices, %0d degenerate, under four idling phases",
             sb.checked, sb.degen_seen);
    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("align_vector_to_z_rotation_core_tb: done, clean");
    else
      $display("align_vector_to_z_rotation_core_tb: done, errors");
    $finish;
  end
endmodule

// ===== filelist.f =====
design/avz_pkg.sv
design/avz_front.sv
design/avz_cell.sv
design/avz_back.sv
design/align_vector_to_z_rotation_core.sv
dv/align_vector_to_z_rotation_core_tb.sv
